/* design/qasr_pkg.sv */
// ----------------------------------------------------------------------------
// qasr_pkg: shared types and constants
// Item and result formats, register map and sizes used by the quote-aware
// substring replacement block.
// ----------------------------------------------------------------------------
package qasr_pkg;

  // default sizes of the lookahead window and of the replacement text
  localparam int DEF_MAX_PATTERN     = 16;
  localparam int DEF_MAX_REPLACEMENT = 16;

  // results one input item may produce; the rest are dropped
  localparam int OUT_LIMIT = 32;
  localparam int OCW       = $clog2(OUT_LIMIT + 1);

  // queue depths
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  // configuration port
  localparam int PAW = 6;
  localparam int PDW = 64;

  // quote characters
  localparam logic [7:0] SINGLE_QUOTE = 8'h27;
  localparam logic [7:0] DOUBLE_QUOTE = 8'h22;

  // register map, index of each register
  typedef enum logic [2:0] {
    REG_PATTERN_LENGTH     = 3'd0,
    REG_REPLACEMENT_LENGTH = 3'd1,
    REG_PATTERN_LOW        = 3'd2,
    REG_PATTERN_HIGH       = 3'd3,
    REG_REPLACEMENT_LOW    = 3'd4,
    REG_REPLACEMENT_HIGH   = 3'd5
  } reg_idx_t;

  // configuration as seen by the back end
  typedef struct packed {
    logic [4:0]  plen;
    logic [4:0]  rlen;
    logic [63:0] pat_lo;
    logic [63:0] pat_hi;
    logic [63:0] rep_lo;
    logic [63:0] rep_hi;
  } cfg_t;

  // one classified text byte
  typedef struct packed {
    logic       sq;
    logic       dq;
    logic [7:0] data;
  } ent_t;

  // one request between front and back end
  typedef struct packed {
    logic last;
    ent_t ent;
  } item_t;

  // one result byte
  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } res_t;

  // back end status
  typedef struct packed {
    logic busy;
    logic repl;
  } bk_stat_t;

endpackage

/* design/qasr_fifo.sv */
// ----------------------------------------------------------------------------
// qasr_fifo: small synchronous queue
// Register-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module qasr_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0] mem_r [DEPTH];
  logic [AW-1:0] wptr_r, rptr_r;
  logic [AW:0]   cnt_r;
  logic          wr_ok, rd_ok;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign wr_ok   = wr_en && !full;
  assign rd_ok   = rd_en && !empty;
  assign rd_data = mem_r[rptr_r];

  // store the incoming request
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (wr_ok) begin
        wptr_r <= (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
      end
      if (rd_ok) begin
        rptr_r <= (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
      end
      if (wr_ok && !rd_ok) begin
        cnt_r <= cnt_r + (AW+1)'(1);
      end else if (rd_ok && !wr_ok) begin
        cnt_r <= cnt_r - (AW+1)'(1);
      end
    end
  end

endmodule

/* design/qasr_front.sv */
// ----------------------------------------------------------------------------
// qasr_front: input side
// Accepts text bytes, marks quote characters and queues them for the back end.
// ----------------------------------------------------------------------------
module qasr_front import qasr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       mid_pop,
  output item_t      mid_item,
  output logic       mid_empty
);

  item_t                    cls;
  logic [$bits(item_t)-1:0] rd_vec;

  // classify the byte
  always_comb begin
    cls.last     = in_last;
    cls.ent.sq   = (in_byte == SINGLE_QUOTE);
    cls.ent.dq   = (in_byte == DOUBLE_QUOTE);
    cls.ent.data = in_byte;
  end

  qasr_fifo #(
    .W     ($bits(item_t)),
    .DEPTH (MID_DEPTH)
  ) u_midq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (cls),
    .full    (full),
    .rd_en   (mid_pop),
    .rd_data (rd_vec),
    .empty   (mid_empty)
  );

  assign mid_item = item_t'(rd_vec);

endmodule

/* design/qasr_cfg.sv */
// ----------------------------------------------------------------------------
// qasr_cfg: configuration registers
// APB-style register file holding pattern and replacement settings.
// ----------------------------------------------------------------------------
module qasr_cfg import qasr_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [PAW-1:0] paddr,
  input  logic [PDW-1:0] pwdata,
  output logic [PDW-1:0] prdata,
  output logic           pready,
  output cfg_t           cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[PAW-1:3]);
  assign cfg    = cfg_r;

  // write a register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr) begin
      case (idx)
        REG_PATTERN_LENGTH:     cfg_r.plen   <= pwdata[4:0];
        REG_REPLACEMENT_LENGTH: cfg_r.rlen   <= pwdata[4:0];
        REG_PATTERN_LOW:        cfg_r.pat_lo <= pwdata;
        REG_PATTERN_HIGH:       cfg_r.pat_hi <= pwdata;
        REG_REPLACEMENT_LOW:    cfg_r.rep_lo <= pwdata;
        REG_REPLACEMENT_HIGH:   cfg_r.rep_hi <= pwdata;
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      REG_PATTERN_LENGTH:     prdata = {59'd0, cfg_r.plen};
      REG_REPLACEMENT_LENGTH: prdata = {59'd0, cfg_r.rlen};
      REG_PATTERN_LOW:        prdata = cfg_r.pat_lo;
      REG_PATTERN_HIGH:       prdata = cfg_r.pat_hi;
      REG_REPLACEMENT_LOW:    prdata = cfg_r.rep_lo;
      REG_REPLACEMENT_HIGH:   prdata = cfg_r.rep_hi;
      default:                prdata = '0;
    endcase
  end

endmodule

/* design/qasr_back.sv */
// ----------------------------------------------------------------------------
// qasr_back: matching engine
// Holds the lookahead window and quote state, decides one byte or one match per
// cycle if the output has room, emits rewritten text via a one-entry hold stage.
// ----------------------------------------------------------------------------
module qasr_back import qasr_pkg::*; #(
  parameter int MAX_PATTERN     = DEF_MAX_PATTERN,
  parameter int MAX_REPLACEMENT = DEF_MAX_REPLACEMENT
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  item_t    mid_item,
  input  logic     mid_empty,
  output logic     mid_pop,
  input  logic     out_full,
  output logic     out_push,
  output res_t     out_res,
  output bk_stat_t stat
);

  localparam int CW = $clog2(MAX_PATTERN + 1);
  localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int SW = IW + 1;
  localparam int RW = $clog2(MAX_REPLACEMENT + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_REPL = 3'b100
  } state_t;

  function automatic logic [7:0] byte_at(input logic [63:0] lo, input logic [63:0] hi,
                                         input logic [6:0] k);
    logic [7:0] b;
    b = 8'h00;
    if (k < 7'd8) begin
      b = lo[{k[2:0], 3'b000} +: 8];
    end else if (k < 7'd16) begin
      b = hi[{k[2:0], 3'b000} +: 8];
    end
    return b;
  endfunction

  state_t          state_r, state_nxt;
  ent_t            win_r [MAX_PATTERN];
  ent_t            win_e [MAX_PATTERN];
  ent_t            win_nxt [MAX_PATTERN];
  logic [CW-1:0]   cnt_r, cnt_e, cnt_nxt;
  logic            sq_r, dq_r, sq_nxt, dq_nxt;
  logic            last_r, last_e;
  logic [RW-1:0]   ridx_r, ridx_nxt;
  logic [OCW-1:0]  ocnt_r, ocnt_e;
  logic            pend_v_r, pend_flush_r, pend_last_r;
  logic [7:0]      pend_data_r;

  logic [6:0]      plen7, rlen7;
  logic [CW-1:0]   plen, drop_n;
  logic [RW-1:0]   rlen;
  logic [7:0]      pat_b [MAX_PATTERN];
  logic            hit, adv, take, act;
  logic            emit_req, emit_ok, drop, repl_nxt, stop, end_step;
  logic [7:0]      emit_data;
  logic [SW-1:0]   src;
  ent_t            head, head_n;

  // clip the lengths to the configured limits
  always_comb begin
    plen7 = {2'b00, cfg.plen};
    if (plen7 > 7'(MAX_PATTERN)) begin
      plen7 = 7'(MAX_PATTERN);
    end
    rlen7 = {2'b00, cfg.rlen};
    if (rlen7 > 7'(MAX_REPLACEMENT)) begin
      rlen7 = 7'(MAX_REPLACEMENT);
    end
  end

  assign plen = plen7[CW-1:0];
  assign rlen = rlen7[RW-1:0];

  // pattern bytes by position
  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      pat_b[k] = byte_at(cfg.pat_lo, cfg.pat_hi, 7'(k));
    end
  end

  assign adv  = !out_full;
  assign take = adv && (state_r == ST_IDLE) && !mid_empty;
  assign act  = adv && (take || (state_r != ST_IDLE));

  // append the new byte to the window
  always_comb begin
    win_e  = win_r;
    cnt_e  = cnt_r;
    last_e = last_r;
    ocnt_e = ocnt_r;
    if (take) begin
      last_e = mid_item.last;
      ocnt_e = '0;
      if (cnt_r < CW'(MAX_PATTERN)) begin
        win_e[cnt_r[IW-1:0]] = mid_item.ent;
        cnt_e = cnt_r + CW'(1);
      end
    end
  end

  // compare the window against the pattern
  always_comb begin
    hit = 1'b1;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if ((CW'(k) < plen) && (win_e[k].data != pat_b[k])) begin
        hit = 1'b0;
      end
    end
  end

  assign head = win_e[0];

  // decide the byte at the front of the window
  always_comb begin
    emit_req  = 1'b0;
    emit_data = head.data;
    drop      = 1'b0;
    drop_n    = CW'(1);
    sq_nxt    = sq_r;
    dq_nxt    = dq_r;
    repl_nxt  = 1'b0;
    ridx_nxt  = ridx_r;
    if (act) begin
      if (state_r == ST_REPL) begin
        emit_req  = 1'b1;
        emit_data = byte_at(cfg.rep_lo, cfg.rep_hi, 7'(ridx_r));
        if (ridx_r == rlen - RW'(1)) begin
          drop   = 1'b1;
          drop_n = plen;
        end else begin
          repl_nxt = 1'b1;
          ridx_nxt = ridx_r + RW'(1);
        end
      end else if (cnt_e != '0) begin
        if (head.sq && !dq_r) begin
          sq_nxt   = !sq_r;
          emit_req = 1'b1;
          drop     = 1'b1;
        end else if (head.dq && !sq_r) begin
          dq_nxt   = !dq_r;
          emit_req = 1'b1;
          drop     = 1'b1;
        end else if ((plen == '0) || sq_r || dq_r) begin
          emit_req = 1'b1;
          drop     = 1'b1;
        end else if (cnt_e < plen) begin
          // flush only at the end of the text
          if (last_e) begin
            emit_req = 1'b1;
            drop     = 1'b1;
          end
        end else if (hit) begin
          if (rlen == '0) begin
            drop   = 1'b1;
            drop_n = plen;
          end else begin
            emit_req  = 1'b1;
            emit_data = byte_at(cfg.rep_lo, cfg.rep_hi, 7'd0);
            if (rlen == RW'(1)) begin
              drop   = 1'b1;
              drop_n = plen;
            end else begin
              repl_nxt = 1'b1;
              ridx_nxt = RW'(1);
            end
          end
        end else begin
          emit_req = 1'b1;
          drop     = 1'b1;
        end
      end
    end
  end

  // shift the decided bytes out of the window
  always_comb begin
    win_nxt = win_e;
    cnt_nxt = cnt_e;
    src     = '0;
    if (drop) begin
      cnt_nxt = cnt_e - drop_n;
      for (int i = 0; i < MAX_PATTERN; i++) begin
        src = SW'(i) + SW'(drop_n);
        if (src < SW'(MAX_PATTERN)) begin
          win_nxt[i] = win_e[src[IW-1:0]];
        end
      end
    end
  end

  assign head_n = win_nxt[0];

  // stop when the window is empty or its front cannot be decided yet
  always_comb begin
    stop = !repl_nxt &&
           ((cnt_nxt == '0) ||
            (!last_e && (plen != '0) && (cnt_nxt < plen) && !sq_nxt && !dq_nxt &&
             !head_n.sq && !head_n.dq));
  end

  assign end_step = act && stop;
  assign emit_ok  = emit_req && (ocnt_e < OCW'(OUT_LIMIT));

  always_comb begin
    state_nxt = state_r;
    if (act) begin
      if (repl_nxt) begin
        state_nxt = ST_REPL;
      end else if (stop) begin
        state_nxt = ST_IDLE;
      end else begin
        state_nxt = ST_SCAN;
      end
    end
  end

  // release the held result on the next emit or at the end of a step
  assign out_push     = adv && pend_v_r && (emit_ok || pend_flush_r);
  assign out_res.last = pend_flush_r ? pend_last_r : 1'b0;
  assign out_res.data = pend_data_r;

  assign mid_pop   = take;
  assign stat.busy = (state_r != ST_IDLE);
  assign stat.repl = (state_r == ST_REPL);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      sq_r         <= 1'b0;
      dq_r         <= 1'b0;
      last_r       <= 1'b0;
      ocnt_r       <= '0;
      pend_v_r     <= 1'b0;
      pend_flush_r <= 1'b0;
      pend_last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (act) begin
        last_r <= last_e;
        ocnt_r <= ocnt_e + OCW'(emit_ok);
        if (end_step && last_e) begin
          cnt_r <= '0;
          sq_r  <= 1'b0;
          dq_r  <= 1'b0;
        end else begin
          cnt_r <= cnt_nxt;
          sq_r  <= sq_nxt;
          dq_r  <= dq_nxt;
        end
      end
      if (emit_ok) begin
        pend_v_r     <= 1'b1;
        pend_flush_r <= end_step;
        pend_last_r  <= last_e;
      end else if (out_push) begin
        pend_v_r     <= 1'b0;
        pend_flush_r <= 1'b0;
      end else if (end_step) begin
        pend_flush_r <= 1'b1;
        pend_last_r  <= last_e;
      end
    end
  end

  // window and payload
  always_ff @(posedge clk) begin
    if (act) begin
      win_r  <= win_nxt;
      ridx_r <= ridx_nxt;
    end
    if (emit_ok) begin
      pend_data_r <= emit_data;
    end
  end

endmodule

/* design/quote_aware_substring_replace.sv */
// Path: a result passes the request queue, the back end and its hold register, then the
// result queue; a byte that may start the pattern waits until pattern_length bytes are in
// the window or the text ends.
// Throughput: one byte per cycle while the result queue has room and the back end is idle;
// a match holds the back end until every replacement byte has been emitted.
// Reset: synchronous, active low; clears quote state, window count, queues and
// registers at once. No clearing pass.
// ----------------------------------------------------------------------------
// quote_aware_substring_replace: top level
// Rewrites a byte stream, replacing a configured pattern outside quotes.
// ----------------------------------------------------------------------------
module quote_aware_substring_replace import qasr_pkg::*; #(
  parameter int MAX_PATTERN     = DEF_MAX_PATTERN,
  parameter int MAX_REPLACEMENT = DEF_MAX_REPLACEMENT
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           full,
  input  logic [7:0]     in_byte,
  input  logic           in_last,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     out_byte,
  output logic           out_last,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [PAW-1:0] paddr,
  input  logic [PDW-1:0] pwdata,
  output logic [PDW-1:0] prdata,
  output logic           pready
);

  cfg_t                    cfg;
  item_t                   mid_item;
  logic                    mid_empty, mid_pop;
  logic                    out_full, out_push;
  res_t                    out_res;
  logic [$bits(res_t)-1:0] out_vec;
  res_t                    head_res;
  bk_stat_t                bk_stat;

  qasr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  qasr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .mid_pop   (mid_pop),
    .mid_item  (mid_item),
    .mid_empty (mid_empty)
  );

  qasr_back #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .mid_item  (mid_item),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_res   (out_res),
    .stat      (bk_stat)
  );

  // hold results until taken
  qasr_fifo #(
    .W     ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (out_push),
    .wr_data (out_res),
    .full    (out_full),
    .rd_en   (pop),
    .rd_data (out_vec),
    .empty   (empty)
  );

  assign head_res = res_t'(out_vec);
  assign out_byte = head_res.data;
  assign out_last = head_res.last;

`ifndef SYNTHESIS
  a_repl_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.repl |-> !mid_pop)
    else $error("back end took a request while emitting a replacement");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    mid_pop |-> !mid_empty)
    else $error("back end popped an empty request queue");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> !out_full)
    else $error("result pushed into a full result queue");
`endif

endmodule
